// ===== rtl/ltk_pkg.sv =====
// Shared types and constants for the latency top-k tracker.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ltk_pkg;

   // Word field widths
   localparam int OP_W     = 2;
   localparam int TIME_W   = 64;
   localparam int STATUS_W = 2;
   localparam int KEPT_W   = 7;

   // Register port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SAMPLING = 1'b0;   // register index, taken from paddr[2]

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_POP   = 2'd2
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UP_RD,
      S_UP_CMP,
      S_TOP_CMP,
      S_POP_LD,
      S_DN_RD,
      S_DN_CMP,
      S_FINISH
   } state_type;

   // Heap read address selection
   typedef enum logic [1:0] {
      RD_TOP,
      RD_PARENT,
      RD_CHILD,
      RD_POP
   } rd_mode_type;

   // Heap write selection
   typedef enum logic [1:0] {
      WR_NONE,
      WR_HOLE,
      WR_PARENT,
      WR_CHILD
   } wr_mode_type;

   // Heap position update
   typedef enum logic [2:0] {
      POS_KEEP,
      POS_COUNT,
      POS_ZERO,
      POS_PARENT,
      POS_CHILD
   } pos_mode_type;

   // Moving value update
   typedef enum logic [1:0] {
      HOLE_KEEP,
      HOLE_LAT,
      HOLE_TAIL
   } hole_mode_type;

   // Controller to datapath commands
   typedef struct packed {
      logic          req_ready;
      logic          set_start;
      logic          set_status;
      status_type    status;
      rd_mode_type   rd_mode;
      wr_mode_type   wr_mode;
      pos_mode_type  pos_mode;
      hole_mode_type hole_mode;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          set_value;
      logic          load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic   req_valid;
      op_type op;
      logic   sampling;
      logic   full;
      logic   empty;
      logic   pos_zero;
      logic   left_ok;
      logic   up_less;
      logic   top_less;
      logic   child_less;
      logic   out_free;
   } stat_type;

endpackage

// ===== rtl/ltk_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on ltk_pkg for field widths.
`timescale 1ns / 1ps

interface ltk_req_if;
   logic                        valid;
   logic                        ready;
   logic [ltk_pkg::OP_W-1:0]    op;
   logic [ltk_pkg::TIME_W-1:0]  time_ns;

   modport source (output valid, output op, output time_ns, input ready);
   modport sink   (input valid, input op, input time_ns, output ready);
endinterface

interface ltk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ltk_pkg::STATUS_W-1:0]  status;
   logic [ltk_pkg::TIME_W-1:0]    value;
   logic [ltk_pkg::KEPT_W-1:0]    kept_count;

   modport source (output valid, output status, output value, output kept_count,
                   input ready);
   modport sink   (input valid, input status, input value, input kept_count,
                   output ready);
endinterface

// ===== rtl/ltk_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ltk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
   output logic [WIDTH-1:0]                           rdata_a,
   output logic [WIDTH-1:0]                           rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== rtl/ltk_ctrl.sv =====
// Controller for the latency top-k tracker: decodes each request word and
// sequences heap sift-up and sift-down steps. Depends on ltk_pkg.
`timescale 1ns / 1ps

module ltk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  ltk_pkg::stat_type stat,
   output ltk_pkg::cmd_type  cmd
);

   ltk_pkg::state_type state_ff;
   ltk_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltk_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ltk_pkg::S_IDLE: begin
            if (stat.req_valid) state_in = ltk_pkg::S_DECODE;
         end
         ltk_pkg::S_DECODE: begin
            state_in = ltk_pkg::S_FINISH;
            case (stat.op)
               ltk_pkg::OP_STOP: begin
                  if (stat.sampling) begin
                     state_in = stat.full ? ltk_pkg::S_TOP_CMP : ltk_pkg::S_UP_RD;
                  end
               end
               ltk_pkg::OP_POP: begin
                  if (!stat.sampling && !stat.empty) state_in = ltk_pkg::S_POP_LD;
               end
               default: state_in = ltk_pkg::S_FINISH;
            endcase
         end
         ltk_pkg::S_UP_RD: begin
            state_in = stat.pos_zero ? ltk_pkg::S_FINISH : ltk_pkg::S_UP_CMP;
         end
         ltk_pkg::S_UP_CMP: begin
            state_in = stat.up_less ? ltk_pkg::S_UP_RD : ltk_pkg::S_FINISH;
         end
         ltk_pkg::S_TOP_CMP: begin
            state_in = stat.top_less ? ltk_pkg::S_DN_RD : ltk_pkg::S_FINISH;
         end
         ltk_pkg::S_POP_LD: begin
            state_in = ltk_pkg::S_DN_RD;
         end
         ltk_pkg::S_DN_RD: begin
            state_in = stat.left_ok ? ltk_pkg::S_DN_CMP : ltk_pkg::S_FINISH;
         end
         ltk_pkg::S_DN_CMP: begin
            state_in = stat.child_less ? ltk_pkg::S_DN_RD : ltk_pkg::S_FINISH;
         end
         ltk_pkg::S_FINISH: begin
            if (stat.out_free) state_in = ltk_pkg::S_IDLE;
         end
         default: state_in = ltk_pkg::S_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd           = '0;
      cmd.status    = ltk_pkg::ST_OK;
      cmd.rd_mode   = ltk_pkg::RD_TOP;
      cmd.wr_mode   = ltk_pkg::WR_NONE;
      cmd.pos_mode  = ltk_pkg::POS_KEEP;
      cmd.hole_mode = ltk_pkg::HOLE_KEEP;
      unique case (state_ff)
         ltk_pkg::S_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ltk_pkg::S_DECODE: begin
            cmd.set_status = 1'b1;
            case (stat.op)
               ltk_pkg::OP_START: begin
                  if (stat.sampling) cmd.set_start = 1'b1;
                  else cmd.status = ltk_pkg::ST_IGNORED;
               end
               ltk_pkg::OP_STOP: begin
                  if (!stat.sampling) begin
                     cmd.status = ltk_pkg::ST_IGNORED;
                  end else if (stat.full) begin
                     cmd.rd_mode   = ltk_pkg::RD_TOP;
                     cmd.hole_mode = ltk_pkg::HOLE_LAT;
                  end else begin
                     cmd.pos_mode  = ltk_pkg::POS_COUNT;
                     cmd.hole_mode = ltk_pkg::HOLE_LAT;
                     cmd.cnt_inc   = 1'b1;
                  end
               end
               ltk_pkg::OP_POP: begin
                  if (stat.sampling) cmd.status = ltk_pkg::ST_BUSY;
                  else if (stat.empty) cmd.status = ltk_pkg::ST_EMPTY;
                  else cmd.rd_mode = ltk_pkg::RD_POP;
               end
               default: cmd.status = ltk_pkg::ST_IGNORED;
            endcase
         end
         ltk_pkg::S_UP_RD: begin
            if (stat.pos_zero) cmd.wr_mode = ltk_pkg::WR_HOLE;
            else cmd.rd_mode = ltk_pkg::RD_PARENT;
         end
         ltk_pkg::S_UP_CMP: begin
            if (stat.up_less) begin
               cmd.wr_mode  = ltk_pkg::WR_PARENT;
               cmd.pos_mode = ltk_pkg::POS_PARENT;
            end else begin
               cmd.wr_mode = ltk_pkg::WR_HOLE;
            end
         end
         ltk_pkg::S_TOP_CMP: begin
            if (stat.top_less) cmd.pos_mode = ltk_pkg::POS_ZERO;
         end
         ltk_pkg::S_POP_LD: begin
            cmd.set_value = 1'b1;
            cmd.hole_mode = ltk_pkg::HOLE_TAIL;
            cmd.cnt_dec   = 1'b1;
            cmd.pos_mode  = ltk_pkg::POS_ZERO;
         end
         ltk_pkg::S_DN_RD: begin
            if (stat.left_ok) cmd.rd_mode = ltk_pkg::RD_CHILD;
            else cmd.wr_mode = ltk_pkg::WR_HOLE;
         end
         ltk_pkg::S_DN_CMP: begin
            if (stat.child_less) begin
               cmd.wr_mode  = ltk_pkg::WR_CHILD;
               cmd.pos_mode = ltk_pkg::POS_CHILD;
            end else begin
               cmd.wr_mode = ltk_pkg::WR_HOLE;
            end
         end
         ltk_pkg::S_FINISH: begin
            cmd.load_out = stat.out_free;
         end
         default: cmd.req_ready = 1'b0;
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (stat.req_valid && cmd.req_ready) |=> (state_ff == ltk_pkg::S_DECODE))
      else $error("accepted word did not enter decode");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("response loaded over a pending word");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.req_ready |-> !(cmd.load_out || cmd.set_status || cmd.wr_mode != ltk_pkg::WR_NONE))
      else $error("request ready while an item is in flight");
`endif

endmodule

// ===== rtl/ltk_dp.sv =====
// Datapath for the latency top-k tracker: request capture, start time, heap
// RAM with position and moving-value registers, response register.
// Depends on ltk_pkg, ltk_ifs and ltk_ram.
`timescale 1ns / 1ps

module ltk_dp #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sampling,
   input  ltk_pkg::cmd_type  cmd,
   output ltk_pkg::stat_type stat,
   ltk_req_if.sink           req,
   ltk_rsp_if.source         rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam int TW = ltk_pkg::TIME_W;
   localparam int KW = ltk_pkg::KEPT_W;

   logic [ltk_pkg::OP_W-1:0] op_ff;
   logic [TW-1:0]            time_ff;
   logic [TW-1:0]            start_ff;
   logic [TW-1:0]            hole_ff;
   logic [TW-1:0]            hole_in;
   logic [AW-1:0]            pos_ff;
   logic [AW-1:0]            pos_in;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   ltk_pkg::status_type      res_status_ff;
   logic [TW-1:0]            res_value_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   ltk_pkg::status_type      rsp_status_ff;
   logic [TW-1:0]            rsp_value_ff;
   logic [KW-1:0]            rsp_kept_ff;

   logic                     accept;
   logic [IW-1:0]            left_idx;
   logic [IW-1:0]            right_idx;
   logic                     right_ok;
   logic [AW-1:0]            parent_idx;
   logic [AW-1:0]            raddr_a;
   logic [AW-1:0]            raddr_b;
   logic [TW-1:0]            rdata_a;
   logic [TW-1:0]            rdata_b;
   logic                     we;
   logic [TW-1:0]            wdata;
   logic                     l_less;
   logic                     r_lt_l;
   logic                     r_lt_h;
   logic                     r_pick;
   logic [TW-1:0]            child_val;
   logic [AW-1:0]            child_idx;

   assign accept = req.valid && req.ready;
   assign req.ready = cmd.req_ready;

   // Heap index arithmetic
   assign left_idx   = (IW'(pos_ff) << 1) + IW'(1);
   assign right_idx  = (IW'(pos_ff) << 1) + IW'(2);
   assign right_ok   = right_idx < IW'(count_ff);
   assign parent_idx = AW'((pos_ff - 1'b1) >> 1);

   // Child selection: left wins ties, right only when strictly smaller
   assign l_less     = rdata_a < hole_ff;
   assign r_lt_l     = rdata_b < rdata_a;
   assign r_lt_h     = rdata_b < hole_ff;
   assign r_pick     = right_ok && (l_less ? r_lt_l : r_lt_h);
   assign child_val  = r_pick ? rdata_b : rdata_a;
   assign child_idx  = r_pick ? right_idx[AW-1:0] : left_idx[AW-1:0];

   // Read address select
   always_comb begin
      raddr_a = '0;
      raddr_b = '0;
      unique case (cmd.rd_mode)
         ltk_pkg::RD_TOP: begin
            raddr_a = '0;
            raddr_b = '0;
         end
         ltk_pkg::RD_PARENT: begin
            raddr_a = parent_idx;
            raddr_b = parent_idx;
         end
         ltk_pkg::RD_CHILD: begin
            raddr_a = left_idx[AW-1:0];
            raddr_b = right_idx[AW-1:0];
         end
         ltk_pkg::RD_POP: begin
            raddr_a = '0;
            raddr_b = AW'(count_ff - 1'b1);
         end
         default: raddr_a = '0;
      endcase
   end

   // Write select
   always_comb begin
      we    = 1'b1;
      wdata = hole_ff;
      unique case (cmd.wr_mode)
         ltk_pkg::WR_NONE:   we = 1'b0;
         ltk_pkg::WR_HOLE:   wdata = hole_ff;
         ltk_pkg::WR_PARENT: wdata = rdata_a;
         ltk_pkg::WR_CHILD:  wdata = child_val;
         default:            we = 1'b0;
      endcase
   end

   ltk_ram #(
      .WIDTH (TW),
      .DEPTH (CAPACITY)
   ) u_heap (
      .clock   (clock),
      .we      (we),
      .waddr   (pos_ff),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // Next position and moving value
   always_comb begin
      pos_in = pos_ff;
      case (cmd.pos_mode)
         ltk_pkg::POS_COUNT:  pos_in = AW'(count_ff);
         ltk_pkg::POS_ZERO:   pos_in = '0;
         ltk_pkg::POS_PARENT: pos_in = parent_idx;
         ltk_pkg::POS_CHILD:  pos_in = child_idx;
         default:             pos_in = pos_ff;
      endcase
      hole_in = hole_ff;
      case (cmd.hole_mode)
         ltk_pkg::HOLE_LAT:  hole_in = time_ff - start_ff;
         ltk_pkg::HOLE_TAIL: hole_in = rdata_b;
         default:            hole_in = hole_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      hole_ff <= hole_in;
   end

   // Capture request word
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req.op;
         time_ff <= req.time_ns;
      end
   end

   // Count and start time
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) count_in = count_ff + 1'b1;
      else if (cmd.cnt_dec) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.set_start) start_ff <= time_ff;
      end
   end

   // Hold result until the response register is free
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
         res_value_ff  <= '0;
      end else if (cmd.set_value) begin
         res_value_ff  <= rdata_a;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_kept_ff   <= KW'(count_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.value      = rsp_value_ff;
   assign rsp.kept_count = rsp_kept_ff;

   // Status to controller
   always_comb begin
      stat            = '0;
      stat.req_valid  = req.valid;
      stat.op         = ltk_pkg::op_type'(op_ff);
      stat.sampling   = sampling;
      stat.full       = count_ff == CW'(CAPACITY);
      stat.empty      = count_ff == '0;
      stat.pos_zero   = pos_ff == '0;
      stat.left_ok    = left_idx < IW'(count_ff);
      stat.up_less    = hole_ff < rdata_a;
      stat.top_less   = rdata_a < hole_ff;
      stat.child_less = l_less || r_pick;
      stat.out_free   = !rsp_valid_ff || rsp.ready;
   end

`ifndef ASSERT_OFF
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("kept count moved by more than one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("kept count above capacity");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_value_ff != '0) |-> (rsp_status_ff == ltk_pkg::ST_OK))
      else $error("nonzero value on a failed word");
`endif

endmodule

// ===== rtl/latency_top_k_tracker.sv =====
// Channel        Dir  Protocol    Word
// req_chan       in   valid/ready op, time_ns
// rsp_chan       out  valid/ready status, value, kept_count
// csr_*          in   APB write   sampling_enabled at address 0
//
// One request word is taken at a time; ready is high only when the block is idle.
// Start, ignored and refused words go from decode straight to the finish state.
// Stops sift up from the new leaf, or compare with the top and sift down when full;
// pops load the tail and sift down. Each heap level takes a read and a compare state,
// set by the registered heap RAM read; the block returns to idle after each load.
// Reset clears count, start time, sampling and the response valid; a finished
// response waits in its register while rsp_chan.ready is low.
//
// Top level: CSR register, controller and datapath. Depends on ltk_pkg,
// ltk_ifs, ltk_ctrl, ltk_dp and ltk_ram.
`timescale 1ns / 1ps

module latency_top_k_tracker #(
   parameter int CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   ltk_req_if.sink                            req_chan,
   ltk_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ltk_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ltk_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ltk_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int DW = ltk_pkg::CSR_DATA_W;

   logic              sampling_ff;
   logic              sampling_in;
   logic              csr_write;
   logic              csr_hit;
   ltk_pkg::cmd_type  cmd;
   ltk_pkg::stat_type stat;

   // Register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == ltk_pkg::REG_SAMPLING;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sampling_in = sampling_ff;
      if (csr_write && csr_hit) sampling_in = csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampling_ff <= 1'b0;
      end else begin
         sampling_ff <= sampling_in;
      end
   end

   assign csr_prdata = csr_hit ? DW'(sampling_ff) : '0;

   ltk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ltk_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .sampling (sampling_ff),
      .cmd      (cmd),
      .stat     (stat),
      .req      (req_chan),
      .rsp      (rsp_chan)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the latency top-k tracker: directed corner words, then
// sampling and pop phases with random latencies, idle bursts and backpressure.
// Depends on ltk_pkg, ltk_ifs and the latency_top_k_tracker top level.
`timescale 1ns / 1ps

module tb_top;

   localparam int TW = ltk_pkg::TIME_W;
   localparam int KW = ltk_pkg::KEPT_W;
   localparam int CAPACITY = 64;
   localparam logic [ltk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [ltk_pkg::CSR_ADDR_W-1:0] SAMPLING_ADDR = {ltk_pkg::REG_SAMPLING, 2'b00};
   localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_ITEMS = 650;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      ltk_pkg::status_type status;
      logic [TW-1:0]       value;
      logic [KW-1:0]       kept;
   } rsp_word_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [ltk_pkg::CSR_ADDR_W-1:0]       csr_paddr;
   logic [ltk_pkg::CSR_DATA_W-1:0]       csr_pwdata;
   logic [ltk_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                 csr_pready;

   ltk_req_if req_bus ();
   ltk_rsp_if rsp_bus ();

   // Shadow of the tracker: sorted kept latencies, ascending
   logic [TW-1:0]      model_start = '0;
   bit                 model_sampling = 1'b0;
   logic [TW-1:0]      kept_latencies[$];
   rsp_word_type       pending_rsp[$];
   rsp_word_type       want;

   int  mismatches = 0;
   int  sent_items = 0;
   int  cycles = 0;
   int  stall_left = 0;
   bit  idling_on = 1'b1;
   bit  hold_request = 1'b0;

   latency_top_k_tracker #(.CAPACITY(CAPACITY)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Advance the shadow state by one accepted word and return the expected response
   function automatic rsp_word_type predict_response(logic [ltk_pkg::OP_W-1:0] op,
                                                     logic [TW-1:0] t);
      rsp_word_type  r;
      logic [TW-1:0] lat;
      int            pos;
      r.status = ltk_pkg::ST_OK;
      r.value  = '0;
      case (op)
         ltk_pkg::OP_START: begin
            if (model_sampling) model_start = t;
            else r.status = ltk_pkg::ST_IGNORED;
         end
         ltk_pkg::OP_STOP: begin
            if (!model_sampling) begin
               r.status = ltk_pkg::ST_IGNORED;
            end else begin
               lat = t - model_start;
               // a full store keeps the latency only if it beats the minimum
               if (kept_latencies.size() < CAPACITY || kept_latencies[0] < lat) begin
                  if (kept_latencies.size() == CAPACITY) void'(kept_latencies.pop_front());
                  pos = 0;
                  while (pos < kept_latencies.size() && kept_latencies[pos] <= lat) pos++;
                  kept_latencies.insert(pos, lat);
               end
            end
         end
         ltk_pkg::OP_POP: begin
            if (model_sampling) r.status = ltk_pkg::ST_BUSY;
            else if (kept_latencies.size() == 0) r.status = ltk_pkg::ST_EMPTY;
            else r.value = kept_latencies.pop_front();
         end
         default: r.status = ltk_pkg::ST_IGNORED;
      endcase
      r.kept = KW'(kept_latencies.size());
      return r;
   endfunction

   task automatic note_mismatch(string field, logic [TW-1:0] exp_v,
                                logic [TW-1:0] got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb_top: mismatch on %s at cycle %0d: expected %0h, got %0h",
                  field, cycles, exp_v, got_v);
   endtask

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_bus.value);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               note_mismatch("status", TW'(want.status), TW'(rsp_bus.status));
            if (rsp_bus.value !== want.value)
               note_mismatch("value", want.value, rsp_bus.value);
            if (rsp_bus.kept_count !== want.kept)
               note_mismatch("kept_count", TW'(want.kept), TW'(rsp_bus.kept_count));
         end
      end
   end

   // Drive response ready: long hold on request, else random stall bursts
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offer one request word, optionally after an idle burst; valid stays high on return
   task automatic send_word(logic [ltk_pkg::OP_W-1:0] op, logic [TW-1:0] t);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.time_ns <= t;
      do @(posedge clock); while (!req_bus.ready);
      pending_rsp.push_back(predict_response(op, t));
      sent_items++;
   endtask

   // Drop valid and hold off until every response is back, then let the block settle
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the sampling register; upper data bits are random and must be ignored
   task automatic csr_write(bit enable);
      logic [ltk_pkg::CSR_DATA_W-1:0] data;
      data = $urandom();
      data[0] = enable;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SAMPLING_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_sampling = enable;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One sampling phase of start/stop pairs with some noise, then a pop phase
   task automatic run_phase(int pairs, int pops);
      logic [TW-1:0] t0;
      logic [TW-1:0] lat;
      settle_idle();
      csr_write(1'b1);
      for (int i = 0; i < pairs; i++) begin
         t0 = {$urandom(), $urandom()};
         case ($urandom_range(0, 5))
            0:       lat = TW'($urandom_range(0, 15));
            1:       lat = TW'($urandom_range(0, 100000));
            2:       lat = {$urandom(), $urandom()};
            3:       lat = TIME_MAX - TW'($urandom_range(0, 3));
            default: lat = TW'($urandom());
         endcase
         case ($urandom_range(0, 19))
            0:       send_word(ltk_pkg::OP_POP, t0);
            1:       send_word(OP_UNUSED, t0);
            2:       send_word(ltk_pkg::OP_STOP, t0);
            3:       send_word(ltk_pkg::OP_START, t0);
            default: begin
               send_word(ltk_pkg::OP_START, t0);
               send_word(ltk_pkg::OP_STOP, t0 + lat);
            end
         endcase
      end
      settle_idle();
      csr_write(1'b0);
      for (int i = 0; i < pops; i++) begin
         t0 = {$urandom(), $urandom()};
         case ($urandom_range(0, 15))
            0:       send_word(ltk_pkg::OP_START, t0);
            1:       send_word(ltk_pkg::OP_STOP, t0);
            2:       send_word(OP_UNUSED, t0);
            default: send_word(ltk_pkg::OP_POP, t0);
         endcase
      end
   endtask

   // Sampling is off after reset: pops see an empty store, events are ignored
   task automatic test_idle_defaults();
      send_word(ltk_pkg::OP_POP, '0);
      send_word(ltk_pkg::OP_START, TIME_MAX);
      send_word(ltk_pkg::OP_STOP, TIME_MAX);
      send_word(OP_UNUSED, '0);
   endtask

   // Busy pop, stop without start, wrapped and extreme latencies, zero latency
   task automatic test_sampling_edges();
      settle_idle();
      csr_write(1'b1);
      send_word(ltk_pkg::OP_POP, '0);
      send_word(OP_UNUSED, TIME_MAX);
      send_word(ltk_pkg::OP_STOP, 64'd100);
      send_word(ltk_pkg::OP_START, TIME_MAX);
      send_word(ltk_pkg::OP_STOP, 64'd5);
      send_word(ltk_pkg::OP_START, '0);
      send_word(ltk_pkg::OP_STOP, TIME_MAX);
      send_word(ltk_pkg::OP_START, 64'h8000_0000_0000_1234);
      send_word(ltk_pkg::OP_STOP, 64'h8000_0000_0000_1234);
   endtask

   // Pops come out ascending, then the store runs empty
   task automatic test_pop_order();
      settle_idle();
      csr_write(1'b0);
      repeat (5) send_word(ltk_pkg::OP_POP, '0);
   endtask

   // Hold the response side for a long stretch while words keep coming
   task automatic test_backpressure();
      settle_idle();
      hold_request = 1'b1;
      run_phase(16, 24);
   endtask

   // Random phases; every third one fills the store and exercises eviction
   task automatic test_random_traffic();
      int phase;
      phase = 0;
      while (sent_items < RANDOM_ITEMS) begin
         idling_on = ($urandom_range(0, 3) != 0);
         if (phase % 3 == 0) run_phase($urandom_range(70, 110), $urandom_range(10, 40));
         else run_phase($urandom_range(5, 30), $urandom_range(5, 80));
         phase++;
      end
   endtask

   // Back-to-back traffic with no idling, ending with the store drained
   task automatic test_tail_no_idle();
      idling_on = 1'b0;
      run_phase(40, 100);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = ltk_pkg::OP_START;
      req_bus.time_ns = '0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_idle_defaults();
      test_sampling_edges();
      test_pop_order();
      test_backpressure();
      test_random_traffic();
      test_tail_no_idle();

      settle_idle();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
